>>> rtl/bfds_pkg.sv
// Shared types and constants for the float depth simulation step unit.
// Depends on nothing; used by bfds_mul, bfds_div and the top level.
`default_nettype none

package bfds_pkg;

   // Fixed-point format of depth, velocity and acceleration
   localparam int FRAC_BITS = 16;
   localparam int VEL_LIMIT = 20 << FRAC_BITS;

   // Serial multiplier: multiplicand and multiplier widths, product width
   localparam int MUL_A_W = 30;
   localparam int MUL_B_W = 26;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // Serial divider by a constant (one quotient bit per cycle)
   localparam int DIV_W     = 44;
   localparam int DIV_REM_W = 10;
   localparam int DIV_CNT_W = $clog2(DIV_W + 1);
   localparam logic [DIV_REM_W:0]   DIV_K     = 11'd1000;
   localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 6'd44;

   // Result status codes
   localparam logic [1:0] STATUS_LATCHED = 2'd0;
   localparam logic [1:0] STATUS_SKIPPED = 2'd1;
   localparam logic [1:0] STATUS_STEPPED = 2'd2;
   localparam logic [1:0] STATUS_RESET   = 2'd3;

   // Configuration register indexes
   localparam logic [2:0] CSR_NEUTRAL      = 3'd0;
   localparam logic [2:0] CSR_GAIN         = 3'd1;
   localparam logic [2:0] CSR_DRAG         = 3'd2;
   localparam logic [2:0] CSR_POOL         = 3'd3;
   localparam logic [2:0] CSR_MAX_STEP     = 3'd4;
   localparam logic [2:0] CSR_SENSOR_BOT   = 3'd5;
   localparam logic [2:0] CSR_SURF_PRESS   = 3'd6;
   localparam logic [2:0] CSR_WATER_WEIGHT = 3'd7;

   // Configuration reset values
   localparam logic [16:0] RST_NEUTRAL      = 17'd32768;
   localparam logic [19:0] RST_GAIN         = 20'd3277;
   localparam logic [19:0] RST_DRAG         = 20'd65536;
   localparam logic [22:0] RST_POOL         = 23'd327680;
   localparam logic [13:0] RST_MAX_STEP     = 14'd200;
   localparam logic [19:0] RST_SENSOR_BOT   = 20'd19661;
   localparam logic [17:0] RST_SURF_PRESS   = 18'd101325;
   localparam logic [14:0] RST_WATER_WEIGHT = 15'd9781;

   localparam logic [16:0] CMD_ONE   = 17'h10000;
   localparam logic [22:0] DEPTH_MAX = 23'h7FFFFF;
   localparam logic [20:0] PRESS_MAX = 21'h1FFFFF;

   typedef enum logic [9:0] {
      ST_IDLE = 10'b00_0000_0001,
      ST_BUOY = 10'b00_0000_0010,
      ST_VSQ  = 10'b00_0000_0100,
      ST_DRAG = 10'b00_0000_1000,
      ST_ADT  = 10'b00_0001_0000,
      ST_VDIV = 10'b00_0010_0000,
      ST_VDT  = 10'b00_0100_0000,
      ST_ZDIV = 10'b00_1000_0000,
      ST_PRES = 10'b01_0000_0000,
      ST_OUT  = 10'b10_0000_0000
   } state_type;

   typedef struct packed {
      logic               start;
      logic [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic               done;
      logic [MUL_P_W-1:0] prod;
   } mul_rsp_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] n;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quo;
      logic             rem_nz;
   } div_rsp_type;

endpackage

`default_nettype wire

>>> rtl/bfds_mul.sv
// Bit-serial shift-and-add multiplier for unsigned magnitudes.
// Depends on bfds_pkg for widths and the request/response structs.
`default_nettype none

module bfds_mul (
   input  logic                  clock,
   input  logic                  reset,
   input  bfds_pkg::mul_req_type mul_req,
   output bfds_pkg::mul_rsp_type mul_rsp
);

   logic                           busy_ff, busy_in;
   logic [bfds_pkg::MUL_P_W-1:0]   mcand_ff, mcand_in;
   logic [bfds_pkg::MUL_P_W-1:0]   acc_ff, acc_in;
   logic [bfds_pkg::MUL_B_W-1:0]   mplier_ff, mplier_in;

   always_comb begin
      busy_in   = busy_ff;
      mcand_in  = mcand_ff;
      acc_in    = acc_ff;
      mplier_in = mplier_ff;
      if (mul_req.start) begin
         busy_in   = 1'b1;
         mcand_in  = {{(bfds_pkg::MUL_P_W - bfds_pkg::MUL_A_W){1'b0}}, mul_req.a};
         mplier_in = mul_req.b;
         acc_in    = '0;
      end else if (busy_ff) begin
         if (mplier_ff == '0) begin
            // no multiplier bits left: finish early
            busy_in = 1'b0;
         end else begin
            if (mplier_ff[0]) begin
               acc_in = acc_ff + mcand_ff;
            end
            mcand_in  = {mcand_ff[bfds_pkg::MUL_P_W-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[bfds_pkg::MUL_B_W-1:1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      mcand_ff  <= mcand_in;
      acc_ff    <= acc_in;
      mplier_ff <= mplier_in;
   end

   assign mul_rsp.done = busy_ff && (mplier_ff == '0);
   assign mul_rsp.prod = acc_ff;

endmodule

`default_nettype wire

>>> rtl/bfds_div.sv
// Bit-serial restoring divider by the constant 1000, one quotient bit a cycle.
// Depends on bfds_pkg for widths and the request/response structs.
`default_nettype none

module bfds_div (
   input  logic                  clock,
   input  logic                  reset,
   input  bfds_pkg::div_req_type div_req,
   output bfds_pkg::div_rsp_type div_rsp
);

   logic                             busy_ff, busy_in;
   logic [bfds_pkg::DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [bfds_pkg::DIV_W-1:0]       num_ff, num_in;
   logic [bfds_pkg::DIV_REM_W-1:0]   rem_ff, rem_in;
   logic [bfds_pkg::DIV_REM_W:0]     trial;
   logic [bfds_pkg::DIV_REM_W:0]     trial_sub;
   logic                             qbit;

   always_comb begin
      trial     = {rem_ff, num_ff[bfds_pkg::DIV_W-1]};
      trial_sub = trial - bfds_pkg::DIV_K;
      qbit      = (trial >= bfds_pkg::DIV_K);

      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = bfds_pkg::DIV_STEPS;
         num_in  = div_req.n;
         rem_in  = '0;
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            // shift one dividend bit into the remainder, one quotient bit out
            cnt_in = cnt_ff - 1'b1;
            num_in = {num_ff[bfds_pkg::DIV_W-2:0], qbit};
            rem_in = qbit ? trial_sub[bfds_pkg::DIV_REM_W-1:0]
                          : trial[bfds_pkg::DIV_REM_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
   end

   assign div_rsp.done   = busy_ff && (cnt_ff == '0);
   assign div_rsp.quo    = num_ff;
   assign div_rsp.rem_nz = (rem_ff != '0);

endmodule

`default_nettype wire

>>> rtl/buoyancy_float_depth_sim_step_unit.sv
// Top level of the float depth simulation: one semi-implicit Euler step per tick.
// Depends on bfds_pkg, bfds_mul (serial multiplier) and bfds_div (serial /1000).
`default_nettype none

// Channel  | Direction | Handshake           | Beat carries
// ---------+-----------+---------------------+-------------------------------------------
// req_     | in        | req_valid/req_ready | type, now_ms, command_u, reset_depth
// rsp_     | out       | rsp_valid/rsp_ready | status, depth, velocity, pressure, flags
// csr_     | in        | csr_valid/csr_ready | register index and write data
//
// Every request finishes with the pressure multiply, be it a time latch, a
// zero-step skip or a reset. An integrating tick runs six serial multiplies
// (each stepping through the multiplier bits up to its top set bit) and two
// serial divisions by 1000.
// Reset (synchronous, active high) clears the state and loads register defaults.
// A waiting result is held in the output register; the next beat is accepted
// meanwhile and the unit stalls only at its final hand-over.

module buoyancy_float_depth_sim_step_unit (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_req_type,
   input  logic [31:0]        req_now_ms,
   input  logic [16:0]        req_command_u,
   input  logic signed [23:0] req_reset_depth,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_step_status,
   output logic [22:0]        rsp_sensor_depth,
   output logic signed [21:0] rsp_sink_velocity,
   output logic [20:0]        rsp_pressure_pa,
   output logic               rsp_at_surface,
   output logic               rsp_at_floor,
   // configuration channel
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [22:0]        csr_wdata
);

   localparam int PW    = bfds_pkg::MUL_P_W;
   localparam int FB    = bfds_pkg::FRAC_BITS;
   localparam int SHR_W = PW - FB + 2;
   localparam logic [PW:0] ROUND_UP = {{(PW + 1 - FB){1'b0}}, {FB{1'b1}}};
   localparam logic signed [36:0] VEL_HI = 37'(bfds_pkg::VEL_LIMIT);
   localparam logic signed [36:0] VEL_LO = -VEL_HI;

   // Floor of a signed product shifted right by the fraction bits, from its
   // magnitude and sign: a negative value rounds its magnitude up.
   function automatic logic [SHR_W-1:0] floor_shift(input logic [PW-1:0] mag,
                                                    input logic neg);
      logic [PW:0]      up;
      logic [SHR_W-1:0] lo;
      logic [SHR_W-1:0] hi;
      up = {1'b0, mag} + ROUND_UP;
      lo = {2'b00, mag[PW-1:FB]};
      hi = {1'b0, up[PW:FB]};
      floor_shift = neg ? (~hi + 1'b1) : lo;
   endfunction

   // ---------------------------------------------------------------- registers
   bfds_pkg::state_type state_ff, state_in;
   logic               launch_ff, launch_in;
   logic               latched_ff, latched_in;
   logic [31:0]        last_ff, last_in;
   logic [22:0]        depth_ff, depth_in;
   logic signed [21:0] vel_ff, vel_in;
   logic [1:0]         status_ff, status_in;
   logic               surf_ff, surf_in;
   logic               flr_ff, flr_in;
   logic [13:0]        dt_ff, dt_in;
   logic [16:0]        dmag_ff, dmag_in;
   logic               dneg_ff, dneg_in;
   logic signed [21:0] abuoy_ff, abuoy_in;
   logic signed [26:0] adrag1_ff, adrag1_in;
   logic signed [31:0] accel_ff, accel_in;
   logic [20:0]        pres_ff, pres_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic [22:0]        rsp_depth_ff, rsp_depth_in;
   logic signed [21:0] rsp_vel_ff, rsp_vel_in;
   logic [20:0]        rsp_pres_ff, rsp_pres_in;
   logic               rsp_surf_ff, rsp_surf_in;
   logic               rsp_flr_ff, rsp_flr_in;

   logic [16:0]        neutral_ff, neutral_in;
   logic [19:0]        gain_ff, gain_in;
   logic [19:0]        drag_ff, drag_in;
   logic [22:0]        pool_ff, pool_in;
   logic [13:0]        max_step_ff, max_step_in;
   logic [19:0]        sbot_ff, sbot_in;
   logic [17:0]        surf_p_ff, surf_p_in;
   logic [14:0]        ww_ff, ww_in;

   // ------------------------------------------------------------ arithmetic
   bfds_pkg::mul_req_type mul_req;
   bfds_pkg::mul_rsp_type mul_rsp;
   bfds_pkg::div_req_type div_req;
   bfds_pkg::div_rsp_type div_rsp;

   logic [21:0]        vel_abs;
   logic [26:0]        adrag1_abs;
   logic [31:0]        accel_abs;
   logic [16:0]        u_clamp, nu_clamp;
   logic signed [17:0] cmd_diff;
   logic [17:0]        cmd_diff_abs;
   logic [31:0]        dt_raw;
   logic [13:0]        dt_clamp;
   logic               fs_neg;
   logic [SHR_W-1:0]   fs_val;
   logic signed [31:0] adrag_ext;
   logic [35:0]        dv_mag;
   logic signed [36:0] dv, vsum;
   logic signed [21:0] vel_sat;
   logic [26:0]        dz_mag;
   logic signed [27:0] dz, z_raw, z_clip, zmax_ext;
   logic signed [23:0] zmax;
   logic signed [21:0] vel_clip;
   logic               surf_hit, flr_hit;
   logic [22:0]        press_sum;

   bfds_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   bfds_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      vel_abs    = vel_ff[21] ? -vel_ff : vel_ff;
      adrag1_abs = adrag1_ff[26] ? -adrag1_ff : adrag1_ff;
      accel_abs  = accel_ff[31] ? -accel_ff : accel_ff;

      // commands above full stroke count as full stroke
      u_clamp      = (req_command_u > bfds_pkg::CMD_ONE) ? bfds_pkg::CMD_ONE : req_command_u;
      nu_clamp     = (neutral_ff > bfds_pkg::CMD_ONE) ? bfds_pkg::CMD_ONE : neutral_ff;
      cmd_diff     = $signed({1'b0, u_clamp}) - $signed({1'b0, nu_clamp});
      cmd_diff_abs = cmd_diff[17] ? -cmd_diff : cmd_diff;

      dt_raw   = req_now_ms - last_ff;
      dt_clamp = (dt_raw > {18'b0, max_step_ff}) ? max_step_ff : dt_raw[13:0];

      // floor shift of the product that has just finished
      case (state_ff)
         bfds_pkg::ST_VSQ:  fs_neg = vel_ff[21];
         bfds_pkg::ST_DRAG: fs_neg = adrag1_ff[26];
         default:           fs_neg = dneg_ff;
      endcase
      fs_val    = floor_shift(mul_rsp.prod, fs_neg);
      adrag_ext = {fs_val[30], fs_val[30:0]};

      // velocity update: floor(a*dt/1000), then saturate; only a negative
      // quotient with a remainder rounds its magnitude up
      dv_mag = {1'b0, div_rsp.quo[34:0]} + {35'b0, div_rsp.rem_nz & accel_ff[31]};
      dv     = accel_ff[31] ? -$signed({1'b0, dv_mag}) : $signed({1'b0, dv_mag});
      vsum   = $signed({{15{vel_ff[21]}}, vel_ff}) + dv;
      if (vsum > VEL_HI) begin
         vel_sat = VEL_HI[21:0];
      end else if (vsum < VEL_LO) begin
         vel_sat = VEL_LO[21:0];
      end else begin
         vel_sat = vsum[21:0];
      end

      // depth update: floor(v*dt/1000), then surface, floor and range clamps
      dz_mag   = {1'b0, div_rsp.quo[25:0]} + {26'b0, div_rsp.rem_nz & vel_ff[21]};
      dz       = vel_ff[21] ? -$signed({1'b0, dz_mag}) : $signed({1'b0, dz_mag});
      z_raw    = $signed({5'b0, depth_ff}) + dz;
      zmax     = $signed({1'b0, pool_ff}) - $signed({4'b0, sbot_ff});
      zmax_ext = {{4{zmax[23]}}, zmax};
      z_clip   = z_raw;
      vel_clip = vel_ff;
      surf_hit = 1'b0;
      flr_hit  = 1'b0;
      if (z_raw < 0) begin
         z_clip   = '0;
         surf_hit = 1'b1;
         if (vel_ff < 0) begin
            vel_clip = '0;
         end
      end
      if ((zmax > 0) && (z_clip > zmax_ext)) begin
         z_clip  = zmax_ext;
         flr_hit = 1'b1;
         if (vel_clip > 0) begin
            vel_clip = '0;
         end
      end
      if (z_clip > $signed({5'b0, bfds_pkg::DEPTH_MAX})) begin
         z_clip = $signed({5'b0, bfds_pkg::DEPTH_MAX});
      end

      // hydrostatic pressure with saturation
      press_sum = {5'b0, surf_p_ff} + {1'b0, mul_rsp.prod[FB+21:FB]};
   end

   // multiplier operands and divider starts by step
   always_comb begin
      mul_req.start = 1'b0;
      mul_req.a     = '0;
      mul_req.b     = '0;
      div_req.start = 1'b0;
      div_req.n     = mul_rsp.prod[bfds_pkg::DIV_W-1:0];
      unique case (state_ff)
         bfds_pkg::ST_BUOY: begin
            mul_req.start = launch_ff;
            mul_req.a     = {10'b0, gain_ff};
            mul_req.b     = {9'b0, dmag_ff};
         end
         bfds_pkg::ST_VSQ: begin
            mul_req.start = launch_ff;
            mul_req.a     = {9'b0, vel_abs[20:0]};
            mul_req.b     = {5'b0, vel_abs[20:0]};
         end
         bfds_pkg::ST_DRAG: begin
            mul_req.start = launch_ff;
            mul_req.a     = {10'b0, drag_ff};
            mul_req.b     = adrag1_abs[25:0];
         end
         bfds_pkg::ST_ADT: begin
            mul_req.start = launch_ff;
            mul_req.a     = accel_abs[29:0];
            mul_req.b     = {12'b0, dt_ff};
         end
         bfds_pkg::ST_VDT: begin
            mul_req.start = launch_ff;
            mul_req.a     = {9'b0, vel_abs[20:0]};
            mul_req.b     = {12'b0, dt_ff};
         end
         bfds_pkg::ST_PRES: begin
            mul_req.start = launch_ff;
            mul_req.a     = {7'b0, depth_ff};
            mul_req.b     = {11'b0, ww_ff};
         end
         bfds_pkg::ST_VDIV, bfds_pkg::ST_ZDIV: begin
            div_req.start = launch_ff;
         end
         default: begin
         end
      endcase
   end

   // ------------------------------------------------------------ sequencer
   always_comb begin
      state_in     = state_ff;
      launch_in    = 1'b0;
      latched_in   = latched_ff;
      last_in      = last_ff;
      depth_in     = depth_ff;
      vel_in       = vel_ff;
      status_in    = status_ff;
      surf_in      = surf_ff;
      flr_in       = flr_ff;
      dt_in        = dt_ff;
      dmag_in      = dmag_ff;
      dneg_in      = dneg_ff;
      abuoy_in     = abuoy_ff;
      adrag1_in    = adrag1_ff;
      accel_in     = accel_ff;
      pres_in      = pres_ff;

      // drop the result once taken
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_depth_in  = rsp_depth_ff;
      rsp_vel_in    = rsp_vel_ff;
      rsp_pres_in   = rsp_pres_ff;
      rsp_surf_in   = rsp_surf_ff;
      rsp_flr_in    = rsp_flr_ff;

      unique case (state_ff)
         bfds_pkg::ST_IDLE: begin
            if (req_valid) begin
               surf_in   = 1'b0;
               flr_in    = 1'b0;
               launch_in = 1'b1;
               state_in  = bfds_pkg::ST_PRES;
               if (req_req_type) begin
                  // place the float at rest; negative depth becomes the surface
                  depth_in   = req_reset_depth[23] ? '0 : req_reset_depth[22:0];
                  vel_in     = '0;
                  latched_in = 1'b0;
                  status_in  = bfds_pkg::STATUS_RESET;
               end else if (!latched_ff) begin
                  latched_in = 1'b1;
                  last_in    = req_now_ms;
                  status_in  = bfds_pkg::STATUS_LATCHED;
               end else begin
                  last_in = req_now_ms;
                  if (dt_raw == '0) begin
                     status_in = bfds_pkg::STATUS_SKIPPED;
                  end else begin
                     status_in = bfds_pkg::STATUS_STEPPED;
                     dt_in     = dt_clamp;
                     dmag_in   = cmd_diff_abs[16:0];
                     dneg_in   = cmd_diff[17];
                     state_in  = bfds_pkg::ST_BUOY;
                  end
               end
            end
         end
         bfds_pkg::ST_BUOY: begin
            if (mul_rsp.done) begin
               abuoy_in  = fs_val[21:0];
               launch_in = 1'b1;
               state_in  = bfds_pkg::ST_VSQ;
            end
         end
         bfds_pkg::ST_VSQ: begin
            if (mul_rsp.done) begin
               adrag1_in = fs_val[26:0];
               launch_in = 1'b1;
               state_in  = bfds_pkg::ST_DRAG;
            end
         end
         bfds_pkg::ST_DRAG: begin
            if (mul_rsp.done) begin
               accel_in  = $signed({{10{abuoy_ff[21]}}, abuoy_ff}) - adrag_ext;
               launch_in = 1'b1;
               state_in  = bfds_pkg::ST_ADT;
            end
         end
         bfds_pkg::ST_ADT: begin
            if (mul_rsp.done) begin
               launch_in = 1'b1;
               state_in  = bfds_pkg::ST_VDIV;
            end
         end
         bfds_pkg::ST_VDIV: begin
            if (div_rsp.done) begin
               vel_in    = vel_sat;
               launch_in = 1'b1;
               state_in  = bfds_pkg::ST_VDT;
            end
         end
         bfds_pkg::ST_VDT: begin
            if (mul_rsp.done) begin
               launch_in = 1'b1;
               state_in  = bfds_pkg::ST_ZDIV;
            end
         end
         bfds_pkg::ST_ZDIV: begin
            if (div_rsp.done) begin
               depth_in  = z_clip[22:0];
               vel_in    = vel_clip;
               surf_in   = surf_hit;
               flr_in    = flr_hit;
               launch_in = 1'b1;
               state_in  = bfds_pkg::ST_PRES;
            end
         end
         bfds_pkg::ST_PRES: begin
            if (mul_rsp.done) begin
               pres_in  = (press_sum > {2'b0, bfds_pkg::PRESS_MAX}) ? bfds_pkg::PRESS_MAX
                                                                   : press_sum[20:0];
               state_in = bfds_pkg::ST_OUT;
            end
         end
         bfds_pkg::ST_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_depth_in  = depth_ff;
               rsp_vel_in    = vel_ff;
               rsp_pres_in   = pres_ff;
               rsp_surf_in   = surf_ff;
               rsp_flr_in    = flr_ff;
               state_in      = bfds_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bfds_pkg::ST_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------- configuration
   always_comb begin
      neutral_in  = neutral_ff;
      gain_in     = gain_ff;
      drag_in     = drag_ff;
      pool_in     = pool_ff;
      max_step_in = max_step_ff;
      sbot_in     = sbot_ff;
      surf_p_in   = surf_p_ff;
      ww_in       = ww_ff;
      if (csr_valid) begin
         unique case (csr_index)
            bfds_pkg::CSR_NEUTRAL:      neutral_in = csr_wdata[16:0];
            bfds_pkg::CSR_GAIN: begin
               // a zero gain is refused; keep the previous one
               if (csr_wdata[19:0] != '0) begin
                  gain_in = csr_wdata[19:0];
               end
            end
            bfds_pkg::CSR_DRAG:         drag_in     = csr_wdata[19:0];
            bfds_pkg::CSR_POOL:         pool_in     = csr_wdata[22:0];
            bfds_pkg::CSR_MAX_STEP:     max_step_in = csr_wdata[13:0];
            bfds_pkg::CSR_SENSOR_BOT:   sbot_in     = csr_wdata[19:0];
            bfds_pkg::CSR_SURF_PRESS:   surf_p_in   = csr_wdata[17:0];
            bfds_pkg::CSR_WATER_WEIGHT: ww_in       = csr_wdata[14:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bfds_pkg::ST_IDLE;
         launch_ff    <= 1'b0;
         latched_ff   <= 1'b0;
         last_ff      <= '0;
         depth_ff     <= '0;
         vel_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         neutral_ff   <= bfds_pkg::RST_NEUTRAL;
         gain_ff      <= bfds_pkg::RST_GAIN;
         drag_ff      <= bfds_pkg::RST_DRAG;
         pool_ff      <= bfds_pkg::RST_POOL;
         max_step_ff  <= bfds_pkg::RST_MAX_STEP;
         sbot_ff      <= bfds_pkg::RST_SENSOR_BOT;
         surf_p_ff    <= bfds_pkg::RST_SURF_PRESS;
         ww_ff        <= bfds_pkg::RST_WATER_WEIGHT;
      end else begin
         state_ff     <= state_in;
         launch_ff    <= launch_in;
         latched_ff   <= latched_in;
         last_ff      <= last_in;
         depth_ff     <= depth_in;
         vel_ff       <= vel_in;
         rsp_valid_ff <= rsp_valid_in;
         neutral_ff   <= neutral_in;
         gain_ff      <= gain_in;
         drag_ff      <= drag_in;
         pool_ff      <= pool_in;
         max_step_ff  <= max_step_in;
         sbot_ff      <= sbot_in;
         surf_p_ff    <= surf_p_in;
         ww_ff        <= ww_in;
      end
      status_ff     <= status_in;
      surf_ff       <= surf_in;
      flr_ff        <= flr_in;
      dt_ff         <= dt_in;
      dmag_ff       <= dmag_in;
      dneg_ff       <= dneg_in;
      abuoy_ff      <= abuoy_in;
      adrag1_ff     <= adrag1_in;
      accel_ff      <= accel_in;
      pres_ff       <= pres_in;
      rsp_status_ff <= rsp_status_in;
      rsp_depth_ff  <= rsp_depth_in;
      rsp_vel_ff    <= rsp_vel_in;
      rsp_pres_ff   <= rsp_pres_in;
      rsp_surf_ff   <= rsp_surf_in;
      rsp_flr_ff    <= rsp_flr_in;
   end

   // ------------------------------------------------------------- ports
   assign req_ready         = (state_ff == bfds_pkg::ST_IDLE);
   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_step_status   = rsp_status_ff;
   assign rsp_sensor_depth  = rsp_depth_ff;
   assign rsp_sink_velocity = rsp_vel_ff;
   assign rsp_pressure_pa   = rsp_pres_ff;
   assign rsp_at_surface    = rsp_surf_ff;
   assign rsp_at_floor      = rsp_flr_ff;

endmodule

`default_nettype wire

>>> tb/depth_step_monitor.sv
// Request type codes shared by the bench, and the channel monitor that predicts
// and checks every result beat of the float depth step unit. Depends on bfds_pkg.
`timescale 1ns / 1ps

package float_tb_pkg;
   localparam logic REQ_TICK  = 1'b0;
   localparam logic REQ_RESET = 1'b1;
endpackage

module depth_step_monitor (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic               req_req_type,
   input  logic [31:0]        req_now_ms,
   input  logic [16:0]        req_command_u,
   input  logic signed [23:0] req_reset_depth,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [1:0]         rsp_step_status,
   input  logic [22:0]        rsp_sensor_depth,
   input  logic signed [21:0] rsp_sink_velocity,
   input  logic [20:0]        rsp_pressure_pa,
   input  logic               rsp_at_surface,
   input  logic               rsp_at_floor,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [22:0]        csr_wdata,
   output int unsigned        mismatches,
   output int unsigned        results_due
);
   import bfds_pkg::*;
   import float_tb_pkg::*;

   localparam int CMD_FRAC = 16;

   typedef struct {
      logic [1:0]         status;
      logic [22:0]        depth;
      logic signed [21:0] velocity;
      logic [20:0]        pressure;
      logic               surface;
      logic               floor_hit;
   } float_sample_type;

   float_sample_type expected_samples[$];
   float_sample_type want;
   int unsigned      error_total = 0;

   // model copy of the float state and settings
   logic        clock_held;
   logic [31:0] prev_ms;
   longint      depth_q, vel_q;
   longint      cfg_neutral, cfg_gain, cfg_drag, cfg_pool;
   longint      cfg_max_step, cfg_sensor, cfg_surf, cfg_weight;

   function automatic longint div_ms_floor(input longint x);
      if (x >= 0)
         return x / 1000;
      return -((-x + 999) / 1000);
   endfunction

   // one Euler step (or latch, skip, relocation) and the sample it reports
   function automatic float_sample_type advance_float(input logic rtype,
                                                      input logic [31:0] now,
                                                      input logic [16:0] cmd,
                                                      input logic signed [23:0] rd);
      float_sample_type s;
      logic [31:0]      elapsed;
      longint           dt, u, nu, a_buoy, a_drag, accel, z, zmax, press;
      s.surface   = 1'b0;
      s.floor_hit = 1'b0;
      if (rtype == REQ_RESET) begin
         depth_q    = rd[23] ? 0 : longint'(rd);
         vel_q      = 0;
         clock_held = 1'b0;
         s.status   = STATUS_RESET;
      end else if (!clock_held) begin
         clock_held = 1'b1;
         prev_ms    = now;
         s.status   = STATUS_LATCHED;
      end else begin
         elapsed = now - prev_ms;
         prev_ms = now;
         if (elapsed == 0) begin
            s.status = STATUS_SKIPPED;
         end else begin
            dt = elapsed;
            if (dt > cfg_max_step)
               dt = cfg_max_step;
            u = cmd;
            if (u > longint'(CMD_ONE))
               u = CMD_ONE;
            nu = cfg_neutral;
            if (nu > longint'(CMD_ONE))
               nu = CMD_ONE;
            a_buoy = (cfg_gain * (u - nu)) >>> CMD_FRAC;
            a_drag = (vel_q * (vel_q < 0 ? -vel_q : vel_q)) >>> FRAC_BITS;
            a_drag = (cfg_drag * a_drag) >>> FRAC_BITS;
            accel  = a_buoy - a_drag;
            vel_q  = vel_q + div_ms_floor(accel * dt);
            if (vel_q > longint'(VEL_LIMIT))
               vel_q = VEL_LIMIT;
            if (vel_q < -longint'(VEL_LIMIT))
               vel_q = -longint'(VEL_LIMIT);
            z = depth_q + div_ms_floor(vel_q * dt);
            if (z < 0) begin
               z = 0;
               s.surface = 1'b1;
               if (vel_q < 0)
                  vel_q = 0;
            end
            zmax = cfg_pool - cfg_sensor;
            if (zmax > 0 && z > zmax) begin
               z = zmax;
               s.floor_hit = 1'b1;
               if (vel_q > 0)
                  vel_q = 0;
            end
            if (z > longint'(DEPTH_MAX))
               z = DEPTH_MAX;
            depth_q  = z;
            s.status = STATUS_STEPPED;
         end
      end
      press = cfg_surf + ((cfg_weight * depth_q) >>> FRAC_BITS);
      if (press > longint'(PRESS_MAX))
         press = PRESS_MAX;
      s.depth    = depth_q[22:0];
      s.velocity = vel_q[21:0];
      s.pressure = press[20:0];
      return s;
   endfunction

   task automatic compare_field(input string field, input longint exp_val, input longint act_val);
      if (exp_val != act_val) begin
         $error("%s: expected %0d, actual %0d", field, exp_val, act_val);
         error_total++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg_neutral  = RST_NEUTRAL;
         cfg_gain     = RST_GAIN;
         cfg_drag     = RST_DRAG;
         cfg_pool     = RST_POOL;
         cfg_max_step = RST_MAX_STEP;
         cfg_sensor   = RST_SENSOR_BOT;
         cfg_surf     = RST_SURF_PRESS;
         cfg_weight   = RST_WATER_WEIGHT;
         clock_held   = 1'b0;
         prev_ms      = '0;
         depth_q      = 0;
         vel_q        = 0;
         expected_samples.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_NEUTRAL:      cfg_neutral  = csr_wdata[16:0];
               CSR_GAIN:         if (csr_wdata[19:0] != '0) cfg_gain = csr_wdata[19:0];
               CSR_DRAG:         cfg_drag     = csr_wdata[19:0];
               CSR_POOL:         cfg_pool     = csr_wdata;
               CSR_MAX_STEP:     cfg_max_step = csr_wdata[13:0];
               CSR_SENSOR_BOT:   cfg_sensor   = csr_wdata[19:0];
               CSR_SURF_PRESS:   cfg_surf     = csr_wdata[17:0];
               CSR_WATER_WEIGHT: cfg_weight   = csr_wdata[14:0];
               default: ;
            endcase
         end
         // drain before fill: a beat leaving now never belongs to one entering now
         if (rsp_valid && rsp_ready) begin
            if (expected_samples.size() == 0) begin
               $error("result beat with no request outstanding");
               error_total++;
            end else begin
               want = expected_samples.pop_front();
               compare_field("step_status", want.status, rsp_step_status);
               compare_field("sensor_depth", want.depth, rsp_sensor_depth);
               compare_field("sink_velocity", want.velocity, rsp_sink_velocity);
               compare_field("pressure_pa", want.pressure, rsp_pressure_pa);
               compare_field("at_surface", want.surface, rsp_at_surface);
               compare_field("at_floor", want.floor_hit, rsp_at_floor);
            end
         end
         if (req_valid && req_ready)
            expected_samples.push_back(advance_float(req_req_type, req_now_ms,
                                                     req_command_u, req_reset_depth));
      end
      mismatches  <= error_total;
      results_due <= expected_samples.size();
   end

endmodule

>>> tb/tb_top.sv
// Stimulus and verdict for the float depth step unit: directed ticks and
// relocations, then random tick streams under several register settings.
// Depends on bfds_pkg, float_tb_pkg and depth_step_monitor.
`timescale 1ns / 1ps

module tb_top;
   import bfds_pkg::*;
   import float_tb_pkg::*;

   localparam int CLK_PERIOD   = 8;
   localparam int RESET_CYCLES = 10;
   localparam int QUIET_LIMIT  = 5000;  // cycles with no beat on any channel
   localparam int DRAIN_CYCLES = 300;   // above the slowest integrating step
   localparam int ITEMS_PER_SETTING = 140;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_req_type = REQ_TICK;
   logic [31:0]        req_now_ms = '0;
   logic [16:0]        req_command_u = '0;
   logic signed [23:0] req_reset_depth = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [1:0]         rsp_step_status;
   logic [22:0]        rsp_sensor_depth;
   logic signed [21:0] rsp_sink_velocity;
   logic [20:0]        rsp_pressure_pa;
   logic               rsp_at_surface;
   logic               rsp_at_floor;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [2:0]         csr_index = '0;
   logic [22:0]        csr_wdata = '0;

   int unsigned mismatches;
   int unsigned results_due;

   // idling odds in percent; the receiver's is read at every edge, so update it late
   int unsigned send_idle_pct  = 11;
   int unsigned recv_stall_pct = 82;
   int unsigned quiet_cycles   = 0;
   logic [31:0] sim_ms = '0;  // timestamp carried by the next tick beat

   buoyancy_float_depth_sim_step_unit dut (.*);
   depth_step_monitor monitor (.*);

   always begin
      #(CLK_PERIOD / 2) clock = ~clock;
   end

   // Receiver: stall at random; hold ready low while in reset
   always @(posedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= recv_stall_pct);
   end

   // Watchdog: any beat on any channel restarts the count
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Commands mostly within the stroke, sometimes above full stroke
   function automatic logic [16:0] rand_command();
      case ($urandom_range(9))
         0: return CMD_ONE;
         1: return 17'($urandom_range(65537, 131071));
         default: return 17'($urandom_range(0, 65536));
      endcase
   endfunction

   // Relocation depths: mostly within the pool, some negative, some any 24-bit pattern
   function automatic logic signed [23:0] rand_depth();
      case ($urandom_range(9))
         0, 1: return -24'($urandom_range(1, 6553600));
         2, 3: return 24'($urandom);
         default: return 24'($urandom_range(0, 6553600));
      endcase
   endfunction

   // Present one request beat, with optional idle cycles in front, and hold it
   // until it is taken. Valid is left high so a following beat can go back to back.
   task automatic send_beat(input logic rtype, input logic [31:0] now, input logic [16:0] cmd,
                            input logic signed [23:0] rd);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_req_type    <= rtype;
      req_now_ms      <= now;
      req_command_u   <= cmd;
      req_reset_depth <= rd;
      do @(posedge clock); while (!req_ready);
   endtask

   // Advance the clock of the float by gap ms and send a tick; the unused depth
   // field still carries random bits
   task automatic tick(input logic [31:0] gap, input logic [16:0] cmd);
      sim_ms = sim_ms + gap;
      send_beat(REQ_TICK, sim_ms, cmd, rand_depth());
   endtask

   // Place the float at a depth; the next tick latches a fresh random timestamp
   task automatic relocate(input logic signed [23:0] rd);
      send_beat(REQ_RESET, $urandom, rand_command(), rd);
      sim_ms = $urandom;
   endtask

   // Drop valid and wait until every expected result beat has come back
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (results_due != 0);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [22:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int unsigned pick, gap;
      int          mode, kind;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // ---- Directed part, register defaults, sender idles 11 %, receiver 82 % ----
      sim_ms = 32'd1000;
      tick(0, 17'd0);                 // first tick only latches the time
      tick(0, CMD_ONE);               // same timestamp: skipped
      tick(40, CMD_ONE);              // plain integration
      tick(5000, CMD_ONE);            // long gap clamped to the step limit
      tick(100, 17'h1FFFF);           // command above full stroke
      relocate(24'sd308000);          // just above the pool floor
      tick(0, CMD_ONE);
      tick(200, CMD_ONE);             // sinks through the floor: clamp
      relocate(24'sd0);               // at the surface
      tick(0, 17'd0);
      tick(200, 17'd0);               // rises through the surface: clamp
      relocate(-24'sd6553600);        // negative depths are taken as zero
      relocate(24'sh800000);
      relocate(24'sh7FFFFF);          // deepest relocation
      sim_ms = 32'hFFFF_FFF0;         // elapsed time across the 32-bit wrap
      tick(0, CMD_ONE);
      tick(32, CMD_ONE);

      // a zero gain write must leave the gain alone; a zero step limit freezes motion
      settle();
      write_reg(CSR_GAIN, 23'd0);
      write_reg(CSR_MAX_STEP, 23'd0);
      tick(500, CMD_ONE);

      // neutral command above full stroke, widest step limit
      settle();
      write_reg(CSR_NEUTRAL, 23'h1FFFF);
      write_reg(CSR_MAX_STEP, 23'h3FFF);
      tick(100, 17'd0);

      // strongest sink, no drag, floor disabled: velocity and depth saturate,
      // and the pressure with them
      settle();
      write_reg(CSR_NEUTRAL, 23'd0);
      write_reg(CSR_GAIN, 23'hFFFFF);
      write_reg(CSR_DRAG, 23'd0);
      write_reg(CSR_POOL, 23'd0);
      write_reg(CSR_SENSOR_BOT, 23'hFFFFF);
      write_reg(CSR_SURF_PRESS, 23'h3FFFF);
      write_reg(CSR_WATER_WEIGHT, 23'h7FFF);
      repeat (4) tick(20000, 17'h1FFFF);

      // ---- Random part: three idling regimes, four register settings each ----
      for (mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin send_idle_pct = 11; recv_stall_pct <= 82; end
            1: begin send_idle_pct = 82; recv_stall_pct <= 11; end
            default: begin send_idle_pct = 0; recv_stall_pct <= 0; end
         endcase
         for (kind = 0; kind < 4; kind++) begin
            settle();
            case (kind)
               0: begin  // upper extremes of the working ranges
                  write_reg(CSR_NEUTRAL, 23'd65536);
                  write_reg(CSR_GAIN, 23'd655360);
                  write_reg(CSR_DRAG, 23'd655360);
                  write_reg(CSR_POOL, 23'd6553600);
                  write_reg(CSR_MAX_STEP, 23'd10000);
                  write_reg(CSR_SENSOR_BOT, 23'd655360);
                  write_reg(CSR_SURF_PRESS, 23'd200000);
                  write_reg(CSR_WATER_WEIGHT, 23'd20000);
               end
               1: begin  // lower extremes
                  write_reg(CSR_NEUTRAL, 23'd0);
                  write_reg(CSR_GAIN, 23'd1);
                  write_reg(CSR_DRAG, 23'd0);
                  write_reg(CSR_POOL, 23'd0);
                  write_reg(CSR_MAX_STEP, 23'd1);
                  write_reg(CSR_SENSOR_BOT, 23'd0);
                  write_reg(CSR_SURF_PRESS, 23'd0);
                  write_reg(CSR_WATER_WEIGHT, 23'd1);
               end
               2: begin  // anywhere within the working ranges
                  write_reg(CSR_NEUTRAL, 23'($urandom_range(0, 65536)));
                  write_reg(CSR_GAIN, 23'($urandom_range(1, 655360)));
                  write_reg(CSR_DRAG, 23'($urandom_range(0, 655360)));
                  write_reg(CSR_POOL, 23'($urandom_range(0, 6553600)));
                  write_reg(CSR_MAX_STEP, 23'($urandom_range(1, 10000)));
                  write_reg(CSR_SENSOR_BOT, 23'($urandom_range(0, 655360)));
                  write_reg(CSR_SURF_PRESS, 23'($urandom_range(0, 200000)));
                  write_reg(CSR_WATER_WEIGHT, 23'($urandom_range(1, 20000)));
               end
               default: begin  // any bit pattern the write port carries
                  write_reg(CSR_NEUTRAL, 23'($urandom));
                  write_reg(CSR_GAIN, 23'($urandom));
                  write_reg(CSR_DRAG, 23'($urandom));
                  write_reg(CSR_POOL, 23'($urandom));
                  write_reg(CSR_MAX_STEP, 23'($urandom));
                  write_reg(CSR_SENSOR_BOT, 23'($urandom));
                  write_reg(CSR_SURF_PRESS, 23'($urandom));
                  write_reg(CSR_WATER_WEIGHT, 23'($urandom));
               end
            endcase

            // Mostly tick streams with random gaps and commands; a few relocations
            repeat (ITEMS_PER_SETTING) begin
               pick = $urandom_range(99);
               if (pick < 4) begin
                  relocate(rand_depth());
               end else begin
                  pick = $urandom_range(99);
                  if (pick < 8)
                     gap = 0;
                  else if (pick < 75)
                     gap = $urandom_range(1, 300);
                  else if (pick < 95)
                     gap = $urandom_range(301, 20000);
                  else
                     gap = $urandom;
                  tick(gap, rand_command());
               end
            end
         end
      end

      // ---- Drain and verdict ----
      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

>>> sim.f
rtl/bfds_pkg.sv
rtl/bfds_mul.sv
rtl/bfds_div.sv
rtl/buoyancy_float_depth_sim_step_unit.sv
tb/depth_step_monitor.sv
tb/tb_top.sv
